@@ hdl/crc_codeword_bit_packer_unit_assert.svh @@
// ----------------------------------------------------------------------------
// crc codeword bit packer assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef CRC_CODEWORD_BIT_PACKER_UNIT_ASSERT_SVH
`define CRC_CODEWORD_BIT_PACKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define CBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/cbp_pkg.sv @@
// ----------------------------------------------------------------------------
// cbp_pkg
// shared types, register codes and sizing helpers of the codeword bit packer
// ----------------------------------------------------------------------------
package cbp_pkg;

    localparam int MAX_GEN_BITS_DEF = 16;
    localparam int CMD_DEPTH_DEF    = 2;
    localparam int OUT_DEPTH_DEF    = 2;
    localparam int LEN_W            = 6;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 32;

    localparam logic        RST_WORD_MODE = 1'b1;
    localparam logic [15:0] RST_GEN_BITS  = 16'd11;
    localparam logic [4:0]  RST_GEN_LEN   = 5'd4;
    localparam logic [31:0] RST_MSG_BYTES = 32'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORD_MODE = 3'd0,
        REG_GEN_BITS  = 3'd1,
        REG_GEN_LEN   = 3'd2,
        REG_MSG_BYTES = 3'd3
    } t_cbp_reg;

    typedef struct packed {
        logic             hdr;
        logic             last;
        logic [2:0]       pad;
        logic [LEN_W-1:0] len;
    } t_cbp_ctl;

    typedef struct packed {
        logic [7:0] data;
        logic       hdr;
        logic       last;
    } t_cbp_out;

    function automatic int gen_limit(input int max_gen);
        return (max_gen < 16) ? max_gen : 16;
    endfunction

    // widest codeword group one byte can produce
    function automatic int cw_width(input int max_gen);
        return 2 * gen_limit(max_gen) + 6;
    endfunction

endpackage

@@ hdl/cbp_fifo.sv @@
// ----------------------------------------------------------------------------
// cbp_fifo
// small register queue with registered pointers and a fill count
// ----------------------------------------------------------------------------
module cbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_din,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_dout,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_din;
        end
    end

endmodule

@@ hdl/cbp_front.sv @@
// ----------------------------------------------------------------------------
// cbp_front
// accepts message bytes, tracks message position, builds codewords and header
// ----------------------------------------------------------------------------
module cbp_front #(
    parameter int MAX_GEN_BITS = cbp_pkg::MAX_GEN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_word_mode,
    input  logic [15:0]            i_gen_bits,
    input  logic [4:0]             i_gen_len,
    input  logic [31:0]            i_msg_bytes,
    output cbp_pkg::t_cbp_ctl      o_ctl,
    output logic [cbp_pkg::cw_width(MAX_GEN_BITS)-1:0] o_bits
);
    import cbp_pkg::*;

    localparam int GEN_LIM = gen_limit(MAX_GEN_BITS);
    localparam int CW_W    = cw_width(MAX_GEN_BITS);
    localparam int V_W     = 7 + GEN_LIM;

    logic [31:0]     r_bytes_seen;
    logic            r_header_sent;
    logic [4:0]      gl;
    logic [15:0]     gen;
    logic [16:0]     gmask;
    logic [31:0]     msg_len;
    logic [31:0]     seen_inc;
    logic            is_last;
    logic [V_W-1:0]  cw8;
    logic [V_W-1:0]  cw_hi;
    logic [V_W-1:0]  cw_lo;
    logic [5:0]      w8;
    logic [5:0]      w4;
    logic [2:0]      words_lo;
    logic [2:0]      cwl_lo;
    logic [5:0]      prod;

    // long division exactly as written: xor the generator at every set lead bit
    function automatic logic [V_W-1:0] encode(
        input logic [7:0]  word,
        input logic        nib,
        input logic [15:0] g,
        input logic [4:0]  l
    );
        logic [V_W-1:0] v;
        logic [V_W-1:0] m;
        int             d;
        int             pos;
        d = nib ? 4 : 8;
        v = V_W'(word) << (l - 5'd1);
        for (int i = 0; i < 8; i++) begin
            if (i < d) begin
                pos = d + int'(l) - 2 - i;
                if (v[pos]) begin
                    v = v ^ (V_W'(g) << (d - 1 - i));
                end
            end
        end
        m = (V_W'(1) << (l - 5'd1)) - V_W'(1);
        return (V_W'(word) << (l - 5'd1)) | (v & m);
    endfunction

    always_comb begin
        gl = i_gen_len;
        if (gl == 5'd0) begin
            gl = 5'd1;
        end else if (gl > 5'(GEN_LIM)) begin
            gl = 5'(GEN_LIM);
        end
    end

    assign gmask    = (17'd1 << gl) - 17'd1;
    assign gen      = i_gen_bits & gmask[15:0];
    assign msg_len  = (i_msg_bytes == '0) ? 32'd1 : i_msg_bytes;
    assign seen_inc = r_bytes_seen + 32'd1;
    assign is_last  = (seen_inc == msg_len);

    assign cw8   = encode(i_data_byte, 1'b0, gen, gl);
    assign cw_hi = encode({4'd0, i_data_byte[7:4]}, 1'b1, gen, gl);
    assign cw_lo = encode({4'd0, i_data_byte[3:0]}, 1'b1, gen, gl);
    assign w8    = 6'd7 + 6'(gl);
    assign w4    = 6'd3 + 6'(gl);

    // padding = -(words * codeword length) mod 8
    assign words_lo = i_word_mode ? msg_len[2:0] : {msg_len[1:0], 1'b0};
    assign cwl_lo   = i_word_mode ? w8[2:0] : w4[2:0];
    assign prod     = words_lo * cwl_lo;

    always_comb begin
        o_ctl.hdr  = !r_header_sent;
        o_ctl.last = is_last;
        o_ctl.pad  = 3'd0 - prod[2:0];
        if (i_word_mode) begin
            o_ctl.len = w8;
            o_bits    = CW_W'(cw8);
        end else begin
            o_ctl.len = {w4[4:0], 1'b0};
            o_bits    = (CW_W'(cw_hi) << w4) | CW_W'(cw_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen  <= '0;
            r_header_sent <= 1'b0;
        end else if (i_accept) begin
            if (is_last) begin
                r_bytes_seen  <= '0;
                r_header_sent <= 1'b0;
            end else begin
                r_bytes_seen  <= seen_inc;
                r_header_sent <= 1'b1;
            end
        end
    end

endmodule

@@ hdl/cbp_back.sv @@
// ----------------------------------------------------------------------------
// cbp_back
// bit accumulator: loads codewords, sends the header and full bytes msb first
// ----------------------------------------------------------------------------
module cbp_back #(
    parameter int MAX_GEN_BITS = cbp_pkg::MAX_GEN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  cbp_pkg::t_cbp_ctl      i_ctl,
    input  logic [cbp_pkg::cw_width(MAX_GEN_BITS)-1:0] i_bits,
    output logic                   o_q_pop,
    input  logic                   i_oq_full,
    output logic                   o_push,
    output cbp_pkg::t_cbp_out      o_word
);
    import cbp_pkg::*;

    localparam int CW_W  = cw_width(MAX_GEN_BITS);
    localparam int ACC_W = CW_W + 8;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             have_byte;
    logic             do_flush;
    logic             emit;
    logic             load;
    logic             emit_last;
    logic [ACC_W-1:0] bits_ext;

    assign have_byte = (r_cnt >= CNT_W'(8));
    assign do_flush  = r_last && (r_cnt != '0) && !have_byte;
    assign emit      = have_byte || do_flush;
    assign load      = !emit && !i_q_empty && (!i_ctl.hdr || !i_oq_full);
    assign emit_last = r_last && (r_cnt <= CNT_W'(8));
    assign bits_ext  = ACC_W'(i_bits);
    assign o_q_pop   = load;
    assign o_push    = (emit && !i_oq_full) || (load && i_ctl.hdr);

    always_comb begin
        if (emit) begin
            o_word.hdr  = 1'b0;
            o_word.last = emit_last;
            if (have_byte) begin
                o_word.data = 8'(r_acc >> (r_cnt - CNT_W'(8)));
            end else begin
                o_word.data = 8'(r_acc[7:0] << (4'd8 - 4'(r_cnt)));
            end
        end else begin
            o_word.data = {5'd0, i_ctl.pad};
            o_word.hdr  = 1'b1;
            o_word.last = 1'b0;
        end
    end

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (emit) begin
            if (!i_oq_full) begin
                if (emit_last || !have_byte) begin
                    n_cnt  = '0;
                    n_last = 1'b0;
                end else begin
                    n_cnt = r_cnt - CNT_W'(8);
                end
            end
        end else if (load) begin
            n_last = i_ctl.last;
            if (i_ctl.hdr) begin
                n_acc = bits_ext;
                n_cnt = CNT_W'(i_ctl.pad) + CNT_W'(i_ctl.len);
            end else begin
                n_acc = (r_acc << i_ctl.len) | bits_ext;
                n_cnt = r_cnt + CNT_W'(i_ctl.len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_last <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

@@ hdl/crc_codeword_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// crc_codeword_bit_packer_unit
// a message's header word is registered in the command queue, then in the output
// queue, and its data words follow; the back end loads the next byte only when it
// has nothing left to send, and drains one word a cycle while the output queue has room
// reset: synchronous active low, clears queues and message state, restores
// config defaults (8-bit words, generator 11 of length 4, one byte messages)
// ----------------------------------------------------------------------------
`include "crc_codeword_bit_packer_unit_assert.svh"

module crc_codeword_bit_packer_unit #(
    parameter int MAX_GEN_BITS = cbp_pkg::MAX_GEN_BITS_DEF,
    parameter int CMD_DEPTH    = cbp_pkg::CMD_DEPTH_DEF,
    parameter int OUT_DEPTH    = cbp_pkg::OUT_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [7:0]                      i_data_byte,
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_out_byte,
    output logic                            o_is_header,
    output logic                            o_last_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cbp_pkg::*;

    localparam int CW_W  = cw_width(MAX_GEN_BITS);
    localparam int CMD_W = $bits(t_cbp_ctl) + CW_W;

    logic            r_word_mode;
    logic [15:0]     r_gen_bits;
    logic [4:0]      r_gen_len;
    logic [31:0]     r_msg_bytes;
    logic            accept;
    t_cbp_ctl        fr_ctl;
    logic [CW_W-1:0] fr_bits;
    logic [CMD_W-1:0] q_dout;
    logic            q_empty;
    logic            q_pop;
    t_cbp_ctl        bk_ctl;
    logic [CW_W-1:0] bk_bits;
    logic            bk_push;
    t_cbp_out        bk_word;
    logic            oq_full;
    t_cbp_out        oq_word;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_mode <= RST_WORD_MODE;
            r_gen_bits  <= RST_GEN_BITS;
            r_gen_len   <= RST_GEN_LEN;
            r_msg_bytes <= RST_MSG_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_WORD_MODE: r_word_mode <= i_cfg_data[0];
                REG_GEN_BITS:  r_gen_bits  <= i_cfg_data[15:0];
                REG_GEN_LEN:   r_gen_len   <= i_cfg_data[4:0];
                REG_MSG_BYTES: r_msg_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbp_front #(
        .MAX_GEN_BITS(MAX_GEN_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_data_byte(i_data_byte),
        .i_word_mode(r_word_mode),
        .i_gen_bits (r_gen_bits),
        .i_gen_len  (r_gen_len),
        .i_msg_bytes(r_msg_bytes),
        .o_ctl      (fr_ctl),
        .o_bits     (fr_bits)
    );

    cbp_fifo #(
        .WIDTH(CMD_W),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_din  ({fr_ctl, fr_bits}),
        .o_full (full),
        .i_pop  (q_pop),
        .o_dout (q_dout),
        .o_empty(q_empty)
    );

    assign bk_ctl  = q_dout[CMD_W-1:CW_W];
    assign bk_bits = q_dout[CW_W-1:0];

    cbp_back #(
        .MAX_GEN_BITS(MAX_GEN_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_ctl    (bk_ctl),
        .i_bits   (bk_bits),
        .o_q_pop  (q_pop),
        .i_oq_full(oq_full),
        .o_push   (bk_push),
        .o_word   (bk_word)
    );

    cbp_fifo #(
        .WIDTH($bits(t_cbp_out)),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (bk_push),
        .i_din  (bk_word),
        .o_full (oq_full),
        .i_pop  (pop),
        .o_dout (oq_word),
        .o_empty(empty)
    );

    assign o_out_byte  = oq_word.data;
    assign o_is_header = oq_word.hdr;
    assign o_last_out  = oq_word.last;

    `CBP_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, q_pop, !q_empty, "pop from empty cmd queue")
    `CBP_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, bk_push, !oq_full, "push into full out queue")
    `CBP_ASSERT_IMPL(a_hdr_not_last, i_clk, i_rst_n, bk_push && bk_word.hdr, !bk_word.last, "header flagged last")
    `CBP_ASSERT_NEXT(a_cmd_visible, i_clk, i_rst_n, accept, !q_empty, "accepted word not queued")

endmodule

@@ tb/sv/crc_pack_checker.sv @@
// ----------------------------------------------------------------------------
// crc_pack_checker
// watches the byte, result and register channels of the codeword bit packer,
// keeps its own copy of the registers and packing state, predicts every word
// that an accepted byte produces and compares each popped word field by field
// ----------------------------------------------------------------------------
module crc_pack_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  logic                           full,
    input  logic [7:0]                     data_byte,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [7:0]                     out_byte,
    input  logic                           is_header,
    input  logic                           last_out,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    import cbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GEN_CAP    = 16;
    localparam int SHOW_FAILS = 10;

    logic        word_mode;
    logic [15:0] gen_bits;
    logic [4:0]  gen_len;
    logic [31:0] msg_bytes;

    logic [63:0] acc_bits;
    int          acc_count;
    logic [31:0] bytes_in_msg;
    logic        header_done;

    t_cbp_out    expected_words[$];
    int          fails;

    function automatic int used_gen_len();
        int l;
        l = int'(gen_len);
        if (l < 1) l = 1;
        if (l > GEN_CAP) l = GEN_CAP;
        return l;
    endfunction

    function automatic logic [31:0] used_msg_len();
        return (msg_bytes == 32'd0) ? 32'd1 : msg_bytes;
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic hdr, input logic last);
        t_cbp_out w;
        w.data = b;
        w.hdr  = hdr;
        w.last = last;
        expected_words.push_back(w);
    endfunction

    // long division of one dataword, codeword appended to the accumulator
    function automatic void append_codeword(input logic [7:0] dword, input int d);
        int          l;
        int          w;
        logic [63:0] gen;
        logic [63:0] v;
        logic [63:0] rem_mask;
        l   = used_gen_len();
        gen = 64'(gen_bits) & ((64'd1 << l) - 64'd1);
        w   = d + l - 1;
        v   = 64'(dword) << (l - 1);
        for (int i = 0; i < d; i++) begin
            if (v[w - 1 - i])
                v ^= gen << (d - 1 - i);
        end
        rem_mask  = (64'd1 << (l - 1)) - 64'd1;
        v         = (64'(dword) << (l - 1)) | (v & rem_mask);
        acc_bits  = (acc_bits << w) | v;
        acc_count += w;
    endfunction

    function automatic void pack_byte(input logic [7:0] b);
        logic [31:0] nwords;
        logic [31:0] prod;
        logic [2:0]  pad;
        logic        last;
        logic [7:0]  ob;
        int          d;
        d = word_mode ? 8 : 4;
        if (!header_done) begin
            nwords      = word_mode ? used_msg_len() : used_msg_len() << 1;
            prod        = nwords * 32'(d + used_gen_len() - 1);
            pad         = 3'd0 - prod[2:0];
            add_word({5'd0, pad}, 1'b1, 1'b0);
            acc_bits    = '0;
            acc_count   = int'(pad);
            header_done = 1'b1;
        end
        if (word_mode) begin
            append_codeword(b, 8);
        end else begin
            append_codeword({4'd0, b[7:4]}, 4);
            append_codeword({4'd0, b[3:0]}, 4);
        end
        bytes_in_msg = bytes_in_msg + 32'd1;
        last         = (bytes_in_msg == used_msg_len());
        while (acc_count >= 8) begin
            ob        = 8'(acc_bits >> (acc_count - 8));
            acc_count -= 8;
            add_word(ob, 1'b0, last && acc_count == 0);
        end
        if (last && acc_count > 0) begin
            ob        = 8'(acc_bits << (8 - acc_count));
            acc_count = 0;
            add_word(ob, 1'b0, 1'b1);
        end
        acc_bits = (acc_count > 0) ? acc_bits & ((64'd1 << acc_count) - 64'd1) : '0;
        if (last) begin
            acc_bits     = '0;
            acc_count    = 0;
            bytes_in_msg = '0;
            header_done  = 1'b0;
        end
    endfunction

    function automatic void note_fail(input string msg);
        fails++;
        if (fails <= SHOW_FAILS)
            $display("[%0t] mismatch %0d: %s", $realtime, fails, msg);
    endfunction

    always @(posedge i_clk) begin
        t_cbp_out w;
        if (!i_rst_n) begin
            word_mode    = RST_WORD_MODE;
            gen_bits     = RST_GEN_BITS;
            gen_len      = RST_GEN_LEN;
            msg_bytes    = RST_MSG_BYTES;
            acc_bits     = '0;
            acc_count    = 0;
            bytes_in_msg = '0;
            header_done  = 1'b0;
            expected_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WORD_MODE: word_mode = cfg_data[0];
                    REG_GEN_BITS:  gen_bits  = cfg_data[15:0];
                    REG_GEN_LEN:   gen_len   = cfg_data[4:0];
                    REG_MSG_BYTES: msg_bytes = cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (expected_words.size() == 0) begin
                    note_fail($sformatf("unexpected word data %02h hdr %0b last %0b",
                                        out_byte, is_header, last_out));
                end else begin
                    w = expected_words.pop_front();
                    if (w.data !== out_byte || w.hdr !== is_header || w.last !== last_out)
                        note_fail($sformatf(
                            "expected data %02h hdr %0b last %0b, got data %02h hdr %0b last %0b",
                            w.data, w.hdr, w.last, out_byte, is_header, last_out));
                end
            end
            if (push && !full)
                pack_byte(data_byte);
        end
        pending    <= expected_words.size();
        fail_count <= fails;
    end

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus for the codeword bit packer: directed register settings and bytes
// for the corner cases, then random message phases with random gaps on the
// byte and result sides; checking is done by crc_pack_checker
// ----------------------------------------------------------------------------
module tb_top;
    import cbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 500000;
    localparam int RANDOM_ITEMS = 320;
    localparam int REG_COUNT    = 4;
    localparam int IDX_TOP      = (1 << CFG_IDX_W) - 1;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    logic [7:0]            i_data_byte = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    logic [7:0]            o_out_byte;
    logic                  o_is_header;
    logic                  o_last_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          cycles = 0;
    bit          steady = 1'b0;
    logic [31:0] cur_msg = 32'd1;
    logic [31:0] msg_pos = 32'd0;

    crc_codeword_bit_packer_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_data_byte (i_data_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_is_header (o_is_header),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    crc_pack_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (i_data_byte),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (o_out_byte),
        .is_header  (o_is_header),
        .last_out   (o_last_out),
        .cfg_valid  (i_cfg_valid),
        .cfg_ready  (o_cfg_ready),
        .cfg_index  (i_cfg_index),
        .cfg_data   (i_cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else begin
                pop <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    task automatic feed(input logic [7:0] b);
        int gap;
        @(negedge i_clk);
        push        <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (full);
        msg_pos = msg_pos + 32'd1;
        if (msg_pos == cur_msg) msg_pos = '0;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_MSG_BYTES) cur_msg = (val == 32'd0) ? 32'd1 : val;
    endtask

    // wait for every predicted word, then for any work still in flight
    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic random_setup();
        logic [31:0] r;
        int          k;
        if ($urandom_range(0, 9) < 7) begin
            r    = $urandom;
            r[0] = $urandom_range(0, 1);
            cfg_write(REG_WORD_MODE, r);
        end
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom;
            k = $urandom_range(0, 9);
            if (k == 0) r[15:0] = 16'h0000;
            else if (k == 1) r[15:0] = 16'hFFFF;
            cfg_write(REG_GEN_BITS, r);
        end
        if ($urandom_range(0, 9) < 7) begin
            r = $urandom;
            k = $urandom_range(0, 9);
            if (k == 0) r[4:0] = 5'd0;
            else if (k == 1) r[4:0] = 5'($urandom_range(17, 31));
            else if (k == 2) r[4:0] = 5'd1;
            else if (k == 3) r[4:0] = 5'd16;
            else r[4:0] = 5'($urandom_range(2, 16));
            cfg_write(REG_GEN_LEN, r);
        end
        if ($urandom_range(0, 9) < 7) begin
            k = $urandom_range(0, 19);
            if (k == 0 && msg_pos == 0) r = 32'd0;
            else if (k == 1) r = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
            else r = msg_pos + 32'($urandom_range(1, 8));
            cfg_write(REG_MSG_BYTES, r);
        end
        if ($urandom_range(0, 9) == 0)
            cfg_write(CFG_IDX_W'($urandom_range(REG_COUNT, IDX_TOP)), $urandom);
        steady = ($urandom_range(0, 4) == 0);
    endtask

    initial begin
        int          sent;
        int          n;
        logic [31:0] rem;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, one-byte messages
        feed(8'h00);
        feed(8'hFF);
        feed(8'h80);
        feed(8'h01);
        settle();

        // 4-bit words, widest all-ones generator
        cfg_write(REG_WORD_MODE, 32'd0);
        cfg_write(REG_GEN_BITS, 32'h0000_FFFF);
        cfg_write(REG_GEN_LEN, 32'd16);
        cfg_write(REG_MSG_BYTES, 32'd3);
        feed(8'hFF);
        feed(8'h00);
        feed(8'hA5);
        settle();

        // zero length and zero message size
        cfg_write(REG_WORD_MODE, 32'hFFFF_FFFF);
        cfg_write(REG_GEN_BITS, 32'd0);
        cfg_write(REG_GEN_LEN, 32'd0);
        cfg_write(REG_MSG_BYTES, 32'd0);
        feed(8'h7E);
        feed(8'hFF);
        settle();

        // length above the cap
        cfg_write(REG_WORD_MODE, 32'd0);
        cfg_write(REG_GEN_BITS, 32'hFFFF_8005);
        cfg_write(REG_GEN_LEN, 32'd31);
        cfg_write(REG_MSG_BYTES, 32'd2);
        feed(8'h0F);
        feed(8'hF0);
        settle();

        // unknown index, length one
        cfg_write(CFG_IDX_W'(IDX_TOP), 32'hFFFF_FFFF);
        cfg_write(CFG_IDX_W'(REG_COUNT), 32'd0);
        cfg_write(REG_GEN_LEN, 32'd1);
        cfg_write(REG_WORD_MODE, 32'd1);
        cfg_write(REG_MSG_BYTES, 32'd4);
        feed(8'h3C);
        feed(8'hC3);
        feed(8'h55);
        feed(8'hAA);
        settle();

        // settings changed mid message, leftover bits flushed at the end
        cfg_write(REG_GEN_LEN, 32'd5);
        cfg_write(REG_GEN_BITS, 32'h0000_0035);
        cfg_write(REG_MSG_BYTES, 32'd3);
        feed(8'h01);
        feed(8'hFE);
        settle();
        cfg_write(REG_WORD_MODE, 32'd0);
        cfg_write(REG_GEN_LEN, 32'd6);
        cfg_write(REG_GEN_BITS, 32'h0000_0045);
        feed(8'h99);
        settle();

        // largest message size, then cut short
        cfg_write(REG_MSG_BYTES, 32'hFFFF_FFFF);
        cfg_write(REG_GEN_LEN, 32'd16);
        feed(8'h00);
        feed(8'hFF);
        settle();
        cfg_write(REG_MSG_BYTES, 32'd3);
        cfg_write(REG_WORD_MODE, 32'd1);
        feed(8'h12);
        settle();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            random_setup();
            if (cur_msg <= 32'd64) begin
                rem = cur_msg - msg_pos;
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, int'(rem + cur_msg));
                else
                    n = int'(rem) + $urandom_range(0, 3) * int'(cur_msg);
            end else begin
                n = $urandom_range(1, 12);
            end
            repeat (n) feed(8'($urandom_range(0, 255)));
            sent += n;
            settle();
        end

        @(negedge i_clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
